>>> rtl/nrp_pkg.sv
// ----------------------------------------------------------------------------
// nrp_pkg
// Shared types and constants of the nested region profiler.
// ----------------------------------------------------------------------------
package nrp_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int NUM_ZONES   = 64;
	localparam int ZONE_W      = 6;
	localparam int TS_W        = 32;
	localparam int CNT_W       = 32;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int ZA_W        = $clog2(NUM_ZONES);

	typedef enum logic [1:0] {
		OP_ENTER = 2'd0,
		OP_LEAVE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_MISMATCH = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [ZONE_W-1:0] zone;
		logic [TS_W-1:0]   timestamp;
	} nrp_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] zone_ticks;
		logic [CNT_W-1:0] zone_calls;
		logic [8:0]       nesting_depth;
	} nrp_rsp_t;

	// sequencing commands from the controller
	typedef struct packed {
		logic capture;
		logic fetch;
		logic load;
		logic exec;
	} nrp_cmd_t;

endpackage

>>> rtl/nrp_ctrl.sv
// ----------------------------------------------------------------------------
// nrp_ctrl
// Controller: steps each transaction through stack fetch, totals load and
// writeback, and owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
module nrp_ctrl
	import nrp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output nrp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_FETCH = 4'b0010,
		S_LOAD  = 4'b0100,
		S_EXEC  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.fetch   = 1'b0;
		cmd.load    = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_FETCH;
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				// wait here until the result register can take the new result
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_exec_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!rsp_valid_q || !rsp_stall))
		else $error("writeback while result register is occupied");

	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> ##1 (state_q == S_LOAD))
		else $error("accepted transaction did not reach totals load");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_EXEC))
		else $error("result appeared without writeback");

endmodule

>>> rtl/nrp_dp.sv
// ----------------------------------------------------------------------------
// nrp_dp
// Datapath: nesting stack memory, per-zone tick and call memories, depth
// and mark registers, and the result register.
// ----------------------------------------------------------------------------
module nrp_dp
	import nrp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  nrp_cmd_t cmd,
	input  nrp_req_t req_data,
	output nrp_rsp_t rsp_data
);

	// captured transaction
	logic [1:0]        op_q;
	logic [ZONE_W-1:0] zone_q;
	logic [TS_W-1:0]   ts_q;

	// architectural state
	logic [LVL_W-1:0]  level_q;
	logic [TS_W-1:0]   mark_q;

	logic [ZONE_W-1:0] stk_mem [STACK_DEPTH];
	logic [CNT_W-1:0]  tick_mem [NUM_ZONES];
	logic [CNT_W-1:0]  call_mem [NUM_ZONES];
	logic [NUM_ZONES-1:0] tick_vld_q;
	logic [NUM_ZONES-1:0] call_vld_q;

	// fetched operands
	logic [ZONE_W-1:0] top_q;
	logic [ZA_W-1:0]   tick_addr_q;
	logic [CNT_W-1:0]  tick_rd_q;
	logic [CNT_W-1:0]  call_rd_q;
	logic              tick_ok_q;
	logic              call_ok_q;

	nrp_rsp_t          rsp_q;

	logic [LVL_W-1:0]  top_idx;
	logic [ZA_W-1:0]   tick_addr;
	logic [CNT_W-1:0]  tick_cur;
	logic [CNT_W-1:0]  call_cur;
	logic [TS_W-1:0]   delta;

	// writeback decisions
	logic              push, pop, clr;
	logic              tick_we, call_we;
	logic [CNT_W-1:0]  tick_wd, call_wd;
	logic [ZA_W-1:0]   tick_wa;
	status_t           status;
	logic [LVL_W-1:0]  level_d;

	assign top_idx   = level_q - LVL_W'(1);
	assign tick_addr = (op_t'(op_q) == OP_ENTER) ? ZA_W'(top_q) : ZA_W'(zone_q);
	assign tick_cur  = tick_ok_q ? tick_rd_q : '0;
	assign call_cur  = call_ok_q ? call_rd_q : '0;
	assign delta     = ts_q - mark_q;

	always_comb begin
		push    = 1'b0;
		pop     = 1'b0;
		clr     = 1'b0;
		tick_we = 1'b0;
		call_we = 1'b0;
		tick_wa = tick_addr_q;
		tick_wd = tick_cur + delta;
		call_wd = call_cur + CNT_W'(1);
		status  = ST_OK;
		case (op_t'(op_q))
			OP_ENTER: begin
				if (level_q == LVL_W'(STACK_DEPTH)) begin
					status = ST_OVERFLOW;
				end else begin
					push    = 1'b1;
					call_we = 1'b1;
					tick_we = (level_q != '0);
				end
			end
			OP_LEAVE: begin
				if (level_q == '0) begin
					status = ST_UNDERFLOW;
				end else if (top_q != zone_q) begin
					status = ST_MISMATCH;
				end else begin
					pop     = 1'b1;
					tick_we = 1'b1;
				end
			end
			OP_READ: clr = 1'b1;
			default: ;
		endcase
		level_d = level_q;
		if (push) begin
			level_d = level_q + LVL_W'(1);
		end else if (pop) begin
			level_d = level_q - LVL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= req_data.operation;
			zone_q <= req_data.zone;
			ts_q   <= req_data.timestamp;
		end
		if (cmd.fetch) begin
			// index wraps on an empty stack; the entry is then never used
			top_q <= stk_mem[top_idx[SP_W-1:0]];
		end
		if (cmd.load) begin
			tick_addr_q <= tick_addr;
			tick_rd_q   <= tick_mem[tick_addr];
			tick_ok_q   <= tick_vld_q[tick_addr];
			call_rd_q   <= call_mem[ZA_W'(zone_q)];
			call_ok_q   <= call_vld_q[ZA_W'(zone_q)];
		end
		if (cmd.exec) begin
			if (push) begin
				stk_mem[level_q[SP_W-1:0]] <= zone_q;
			end
			if (tick_we) begin
				tick_mem[tick_wa] <= tick_wd;
			end
			if (call_we) begin
				call_mem[ZA_W'(zone_q)] <= call_wd;
			end
			rsp_q.status        <= status;
			rsp_q.zone_ticks    <= clr ? tick_cur : '0;
			rsp_q.zone_calls    <= clr ? call_cur : '0;
			rsp_q.nesting_depth <= 9'(level_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= '0;
			mark_q     <= '0;
			tick_vld_q <= '0;
			call_vld_q <= '0;
		end else if (cmd.exec) begin
			level_q <= level_d;
			if (push || pop) begin
				mark_q <= ts_q;
			end
			if (tick_we) begin
				tick_vld_q[tick_wa] <= 1'b1;
			end
			if (call_we) begin
				call_vld_q[ZA_W'(zone_q)] <= 1'b1;
			end
			// clearing a zone just drops its valid bits
			if (clr) begin
				tick_vld_q[ZA_W'(zone_q)] <= 1'b0;
				call_vld_q[ZA_W'(zone_q)] <= 1'b0;
			end
		end
	end

	assign rsp_data = rsp_q;

endmodule

>>> rtl/nested_region_profiler_top.sv
// ----------------------------------------------------------------------------
// nested_region_profiler_top
// Exclusive-time profiler for nested code regions with per-zone totals.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_valid/req_stall  nrp_req_t (operation, zone, timestamp)
//  rsp      out  rsp_valid/rsp_stall  nrp_rsp_t (status, ticks, calls, depth)
//
//  each transaction steps through accept, stack top read, totals read and
//  writeback, an order set by the registered reads of the stack and
//  per-zone memories that one event must chain
//  reset clears depth, mark and the per-zone valid bits at once, no sweep
//  a stalled result holds the writeback step; one new request may be taken
//  while the previous result waits
// ----------------------------------------------------------------------------
module nested_region_profiler_top
	import nrp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  nrp_req_t req_data,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output nrp_rsp_t rsp_data
);

	nrp_cmd_t cmd;

	nrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	nrp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req_data),
		.rsp_data (rsp_data)
	);

endmodule
